/* hw/rtl/sts_pkg.sv */
// Shared types, codes and sizes of the sorted table search block.
package sts_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned CountW     = 9;
  localparam int unsigned DataW      = 32;

  // Function codes carried by an input item.
  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0,
    FUNC_EXACT = 3'd1,
    FUNC_FIRST = 3'd2,
    FUNC_LAST  = 3'd3,
    FUNC_COUNT = 3'd4
  } func_e;

  // How one search pass narrows after a match.
  typedef enum logic [1:0] {
    SRCH_EXACT,
    SRCH_FIRST,
    SRCH_LAST
  } search_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    write;
    logic    init;
    search_e kind;
    logic    read;
    logic    update;
    logic    save_first;
    logic    load_out;
    logic    out_count;
  } sts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
  } sts_stat_t;

endpackage

/* hw/rtl/sts_if.sv */
// Handshake channels of the sorted table search block: request and response.
interface sts_req_if
  import sts_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [2:0]               func;
  logic [IdxW-1:0]          entry_index;
  logic signed [DataW-1:0]  item_value;

  modport source (output valid, output func, output entry_index, output item_value,
                  input ready);
  modport sink   (input valid, input func, input entry_index, input item_value,
                  output ready);
endinterface

interface sts_rsp_if
  import sts_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [CountW-1:0]  position;
  logic [CountW-1:0]         occurrence_count;

  modport source (output valid, output found, output position, output occurrence_count,
                  input ready);
  modport sink   (input valid, input found, input position, input occurrence_count,
                  output ready);
endinterface

/* hw/rtl/sts_datapath.sv */
// Datapath: table memory, search bounds, compare and the result register.
module sts_datapath
  import sts_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CountW-1:0]        cfg_wdata_i,
  input  logic [IdxW-1:0]          entry_index_i,
  input  logic signed [DataW-1:0]  item_value_i,
  input  sts_cmd_t                 cmd_i,
  output sts_stat_t                stat_o,
  output logic                     found_o,
  output logic signed [CountW-1:0] position_o,
  output logic [CountW-1:0]        occurrence_count_o
);

  logic signed [DataW-1:0] mem [TableDepth];

  logic [CountW-1:0]       entry_count_q;
  logic signed [DataW-1:0] key_q;
  logic signed [DataW-1:0] rd_q;
  logic signed [CountW:0]  lo_q, hi_q;
  search_e                 kind_q;
  logic                    hit_q;
  logic                    ans_ok_q, first_ok_q;
  logic [IdxW-1:0]         ans_idx_q, first_idx_q;
  logic                    found_q;
  logic signed [CountW-1:0] pos_q;
  logic [CountW-1:0]       cnt_q;

  logic [CountW-1:0]       used;
  logic [CountW:0]         bound_sum;
  logic [IdxW-1:0]         mid;
  logic signed [CountW:0]  mid_up, mid_dn;
  logic [CountW-1:0]       span;

  assign used      = (entry_count_q > CountW'(TableDepth)) ? CountW'(TableDepth)
                                                           : entry_count_q;
  // Both bounds are non-negative while a search is live, so the midpoint is
  // the halved sum of their low bits.
  assign bound_sum = {1'b0, lo_q[CountW-1:0]} + {1'b0, hi_q[CountW-1:0]};
  assign mid       = bound_sum[IdxW:1];
  assign mid_up    = $signed({2'b00, mid}) + (CountW+1)'(1);
  assign mid_dn    = $signed({2'b00, mid}) - (CountW+1)'(1);
  assign span      = {1'b0, ans_idx_q} - {1'b0, first_idx_q} + CountW'(1);

  assign stat_o.busy = (lo_q <= hi_q) && !hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[entry_index_i] <= item_value_i;
    end
    if (cmd_i.read) begin
      rd_q <= mem[mid];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      if (!cmd_i.save_first) begin
        key_q <= item_value_i;
      end
      kind_q   <= cmd_i.kind;
      lo_q     <= '0;
      hi_q     <= $signed({1'b0, used}) - (CountW+1)'(1);
      hit_q    <= 1'b0;
      ans_ok_q <= 1'b0;
    end else if (cmd_i.update) begin
      if (rd_q == key_q) begin
        ans_ok_q  <= 1'b1;
        ans_idx_q <= mid;
        case (kind_q)
          SRCH_EXACT: hit_q <= 1'b1;
          SRCH_FIRST: hi_q  <= mid_dn;
          SRCH_LAST:  lo_q  <= mid_up;
          default:    hit_q <= 1'b1;
        endcase
      end else if (key_q > rd_q) begin
        lo_q <= mid_up;
      end else begin
        hi_q <= mid_dn;
      end
    end
    if (cmd_i.save_first) begin
      first_ok_q  <= ans_ok_q;
      first_idx_q <= ans_idx_q;
    end
    if (cmd_i.load_out) begin
      if (cmd_i.out_count) begin
        found_q <= first_ok_q;
        pos_q   <= first_ok_q ? $signed({1'b0, first_idx_q}) : '1;
        cnt_q   <= (first_ok_q && ans_ok_q && (ans_idx_q >= first_idx_q)) ? span : '0;
      end else begin
        found_q <= ans_ok_q;
        pos_q   <= ans_ok_q ? $signed({1'b0, ans_idx_q}) : '1;
        cnt_q   <= '0;
      end
    end
  end

  assign found_o            = found_q;
  assign position_o         = pos_q;
  assign occurrence_count_o = cnt_q;

endmodule

/* hw/rtl/sts_ctrl.sv */
// Controller: sequences writes, search passes and result delivery.
module sts_ctrl
  import sts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] in_func_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  sts_stat_t  stat_i,
  output sts_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] mode_q;
  logic       pass2_q, pass2_d;
  logic       out_valid_q, out_valid_d;
  logic       in_take;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.kind  = SRCH_EXACT;
    state_d     = state_q;
    pass2_d     = pass2_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          case (in_func_i)
            FUNC_WRITE: cmd_o.write = 1'b1;
            FUNC_EXACT, FUNC_FIRST, FUNC_LAST, FUNC_COUNT: begin
              cmd_o.init = 1'b1;
              pass2_d    = 1'b0;
              state_d    = ST_PROBE;
              case (in_func_i)
                FUNC_FIRST, FUNC_COUNT: cmd_o.kind = SRCH_FIRST;
                FUNC_LAST:              cmd_o.kind = SRCH_LAST;
                default:                cmd_o.kind = SRCH_EXACT;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        if (stat_i.busy) begin
          cmd_o.read = 1'b1;
          state_d    = ST_CMP;
        end else if ((mode_q == FUNC_COUNT) && !pass2_q) begin
          // First pass done: keep its answer, restart for the last match.
          cmd_o.save_first = 1'b1;
          cmd_o.init       = 1'b1;
          cmd_o.kind       = SRCH_LAST;
          pass2_d          = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_CMP: begin
        cmd_o.update = 1'b1;
        state_d      = ST_PROBE;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.out_count = (mode_q == FUNC_COUNT);
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= '0;
      pass2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass2_q     <= pass2_d;
      out_valid_q <= out_valid_d;
      if (in_take) begin
        mode_q <= in_func_i;
      end
    end
  end

endmodule

/* hw/rtl/sorted_table_search.sv */
// Sorted table search: a write item is stored as it is accepted and leaves the block ready
// for the next item; each query probe is a table read (PROBE) followed by a compare (CMP).
// Exact, first and last queries run one pass of at most 9 probes. Count queries run two
// passes, for the first and then the last match; a stalled result holds the next query in
// its finish state. A new item is taken the cycle after a result.
// Reset clears entry_count and the control state; table contents are undefined until written.
module sorted_table_search
  import sts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  sts_req_if.sink           req_i,
  sts_rsp_if.source         rsp_o
);

  // The controller walks each item through its passes; the datapath holds
  // the table, the search bounds and the result register.
  sts_cmd_t  cmd;
  sts_stat_t stat;

  sts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_func_i   (req_i.func),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Write data and search keys are taken straight from the request channel
  // in the cycle the item is accepted.
  sts_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .entry_index_i      (req_i.entry_index),
    .item_value_i       (req_i.item_value),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .found_o            (rsp_o.found),
    .position_o         (rsp_o.position),
    .occurrence_count_o (rsp_o.occurrence_count)
  );

endmodule
